FILE: sv/assert_macros.svh
// Concurrent assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/kht_pkg.sv
package kht_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int REC_W    = CNT_W + TIME_W;

  localparam int S_TDATA_W = ((KEY_W + TIME_W + 7) / 8) * 8;
  localparam int S_PAD_W   = S_TDATA_W - KEY_W - TIME_W;
  localparam int M_TDATA_W = ((SLOT_W + CNT_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - SLOT_W - CNT_W;

  localparam logic [IDX_W:0]   SCAN_END  = (IDX_W + 1)'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_REFRESH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } kht_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } kht_state_t;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  user_key;
    logic [TIME_W-1:0] now_time;
  } kht_req_t;

  typedef struct packed {
    kht_status_t       status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  hit_count;
  } kht_res_t;

endpackage

FILE: sv/kht_ram.sv
module kht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/kht_engine.sv
`include "assert_macros.svh"

module kht_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  kht_pkg::kht_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output kht_pkg::kht_res_t res
);

  import kht_pkg::*;

  kht_state_t state;
  kht_state_t state_next;

  kht_req_t         req_q;
  logic [IDX_W:0]   rd_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx;
  logic [CNT_W-1:0] cnt_q;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [ENTRIES-1:0] occupied;

  logic [KEY_W-1:0] key_rd;
  logic [REC_W-1:0] rec_rd;
  logic             rd_more;
  logic             cmp_hit;
  logic             cmp_last;
  logic [CNT_W-1:0] upd_count;
  logic             commit;
  logic             do_insert;
  logic             key_we;
  logic             rec_we;
  logic [IDX_W-1:0] wr_idx;
  logic [REC_W-1:0] rec_wdata;

  kht_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_idx),
    .wdata (req_q.user_key),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (key_rd)
  );

  kht_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (wr_idx),
    .wdata (rec_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rec_rd)
  );

  assign rd_more  = (rd_idx != SCAN_END);
  assign cmp_hit  = cmp_vld && occupied[cmp_idx] && (key_rd == req_q.user_key);
  assign cmp_last = cmp_vld && (cmp_idx == LAST_IDX);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_hit || cmp_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == S_IDLE);
    res_valid = (state == S_DONE);
    commit    = (state == S_DONE) && res_ready;

    if ((req_q.action == ACT_REFRESH) || (cnt_q == COUNT_MAX)) begin
      upd_count = cnt_q;
    end else begin
      upd_count = cnt_q + COUNT_ONE;
    end

    do_insert      = 1'b0;
    wr_idx         = hit_idx;
    rec_wdata      = {req_q.now_time, upd_count};
    res.status     = ST_FULL;
    res.slot_index = '0;
    res.hit_count  = '0;

    if (hit_q) begin
      res.status     = ST_UPDATED;
      res.slot_index = SLOT_W'(hit_idx);
      res.hit_count  = upd_count;
    end else if (req_q.action == ACT_REFRESH) begin
      res.status = ST_NOT_FOUND;
    end else if (free_found) begin
      do_insert      = 1'b1;
      wr_idx         = free_idx;
      rec_wdata      = {req_q.now_time, COUNT_ONE};
      res.status     = ST_INSERTED;
      res.slot_index = SLOT_W'(free_idx);
      res.hit_count  = COUNT_ONE;
    end

    key_we = commit && do_insert;
    rec_we = commit && (hit_q || do_insert);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occupied <= '0;
      cmp_vld  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q      <= req;
            rd_idx     <= '0;
            cmp_vld    <= 1'b0;
            hit_q      <= 1'b0;
            free_found <= 1'b0;
          end
        end
        S_SCAN: begin
          if (rd_more) begin
            rd_idx <= rd_idx + 1'b1;
          end
          cmp_vld <= rd_more;
          cmp_idx <= rd_idx[IDX_W-1:0];
          if (cmp_vld && !occupied[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (cmp_hit) begin
            hit_q   <= 1'b1;
            hit_idx <= cmp_idx;
            cnt_q   <= rec_rd[CNT_W-1:0];
          end
        end
        S_DONE: begin
          if (key_we) begin
            occupied[free_idx] <= 1'b1;
          end
        end
        default: begin
          cmp_vld <= 1'b0;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_hit_occupied, clk, rst, (state == S_DONE) && hit_q, occupied[hit_idx])
  `ASSERT_IMPLIES(a_free_empty, clk, rst, (state == S_DONE) && free_found, !occupied[free_idx])
  `ASSERT_NEXT(a_insert_grows, clk, rst, key_we, $countones(occupied) == $past($countones(occupied)) + 1)
  `ASSERT_IMPLIES(a_write_in_done, clk, rst, rec_we || key_we, (state == S_DONE) && res_ready)

endmodule

FILE: sv/keyed_heartbeat_table.sv
// Channel   Direction  tdata (low bit up)                tuser
// s_*       in         user_key[63:0], now_time[95:64]   action[0]
// m_*       out        slot_index[3:0], hit_count[35:4]  status[1:0]
//
// The time from accept to the result transaction is set by the key scan: one key memory
// read per cycle, stopping at the first match or after the last entry.
// One request is in flight at a time; s_tready is high only when the engine is idle.
// The result waits in the output register, so a stalled m_tready holds the next
// request only once it finishes its own scan.
// Reset clears every occupied bit at once; no clearing pass is needed.
module keyed_heartbeat_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [kht_pkg::S_TDATA_W-1:0]  s_tdata,  // user_key, now_time
  input  logic                           s_tuser,  // action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [kht_pkg::M_TDATA_W-1:0]  m_tdata,  // slot_index, hit_count, zero pad
  output logic [kht_pkg::STATUS_W-1:0]   m_tuser   // status
);

  import kht_pkg::*;

  kht_req_t req;
  kht_res_t res;
  logic     req_ready;
  logic     res_valid;
  logic     res_ready;

  assign req.action   = s_tuser;
  assign req.user_key = s_tdata[KEY_W-1:0];
  assign req.now_time = s_tdata[KEY_W +: TIME_W];
  assign s_tready     = req_ready;
  assign res_ready    = !m_tvalid || m_tready;

  kht_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {{M_PAD_W{1'b0}}, res.hit_count, res.slot_index};
      m_tuser <= res.status;
    end
  end

endmodule
